@@ src/rfcp_pkg.sv @@
// Shared types and constants for the capture-period tachometer.
`timescale 1ns / 1ps
`default_nettype none

package rfcp_pkg;

    localparam int          DEF_CAPTURE_BITS = 16;
    localparam int          NUM_W            = 32;
    localparam int          CAP_PORT_W       = 16;
    localparam int          OVF_W            = 16;
    localparam int          SPEED_W          = 16;
    localparam logic [31:0] NUM_RESET        = 32'd60000000;
    localparam logic [15:0] OVF_MAX          = 16'hFFFF;
    localparam logic [15:0] SPEED_SAT        = 16'hFFFF;

    localparam logic OP_OVERFLOW = 1'b0;
    localparam logic OP_CAPTURE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

@@ src/rfcp_period.sv @@
// Overflow count and last capture state, and the period between captures.
`timescale 1ns / 1ps
`default_nettype none

module rfcp_period
    import rfcp_pkg::*;
#(
    parameter int CAPTURE_BITS = DEF_CAPTURE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic                  i_operation,
    input  wire logic [CAP_PORT_W-1:0] i_capture_value,
    output logic [NUM_W-1:0]           o_period
);

    localparam int CAP_W = (CAPTURE_BITS < CAP_PORT_W) ? CAPTURE_BITS : CAP_PORT_W;
    localparam logic [CAP_PORT_W-1:0] CAP_MASK =
        CAP_PORT_W'((17'd1 << CAP_W) - 17'd1);

    logic [OVF_W-1:0]            r_ovf;
    logic [OVF_W-1:0]            n_ovf;
    logic [CAP_PORT_W-1:0]       r_last;
    logic [CAP_PORT_W-1:0]       n_last;
    logic [CAP_PORT_W-1:0]       cap_masked;
    logic [NUM_W+OVF_W-1:0]      ovf_wide;
    logic [NUM_W-1:0]            diff;

    assign cap_masked = i_capture_value & CAP_MASK;
    assign ovf_wide   = {{NUM_W{1'b0}}, r_ovf} << CAPTURE_BITS;
    assign diff       = {{(NUM_W-CAP_PORT_W){1'b0}}, cap_masked}
                      - {{(NUM_W-CAP_PORT_W){1'b0}}, r_last};
    assign o_period   = ovf_wide[NUM_W-1:0] + diff;

    always_comb begin
        n_ovf  = r_ovf;
        n_last = r_last;
        if (i_accept) begin
            if (i_operation == OP_CAPTURE) begin
                n_ovf  = '0;
                n_last = cap_masked;
            end else if (r_ovf != OVF_MAX) begin
                n_ovf = r_ovf + OVF_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf  <= '0;
            r_last <= '0;
        end else begin
            r_ovf  <= n_ovf;
            r_last <= n_last;
        end
    end

endmodule

`default_nettype wire

@@ src/rfcp_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rfcp_div
    import rfcp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_dividend,
    input  wire logic [NUM_W-1:0] i_divisor,
    output t_div_status           o_status,
    output logic [NUM_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] n_rem;
    logic [NUM_W-1:0] r_quo;
    logic [NUM_W-1:0] n_quo;
    logic [NUM_W-1:0] r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [NUM_W:0]   trial;
    logic [NUM_W:0]   diff;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign diff  = trial - {1'b0, r_dsr};

    always_comb begin
        if (!diff[NUM_W]) begin
            n_rem = diff[NUM_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], 1'b1};
        end else begin
            n_rem = trial[NUM_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

endmodule

`default_nettype wire

@@ src/rpm_from_capture_period_top.sv @@
// Engine speed from ignition pulse capture period: sequencer and output register.
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries an operation bit and a
//   16-bit capture value. Operation 0 is a timer overflow tick: it bumps a
//   saturating overflow count and gives no result. Operation 1 is a capture:
//   the period since the previous capture is formed and the numerator is
//   divided by it.
//   Output channel (o_out_valid / i_out_stall) carries speed_rpm and the
//   zero_interval flag, one request per capture.
//   The user must write the numerator through i_cfg_we / i_cfg_wdata only while
//   idle; the block itself does not enforce this.
// Sequence:
//   A divided capture runs 32 divider steps, then the quotient is latched, then
//   the output register is loaded. A zero period skips the divider. The input
//   channel stalls while the divider runs or a result waits to be loaded, so
//   divided captures never overlap. Overflow ticks are accepted while idle.
// Reset clears the overflow count, the stored capture and the output valid,
// and loads the numerator with 60000000. When the receiver stalls, the
// output request holds; a following capture may divide meanwhile and then
// waits for the output register.
`timescale 1ns / 1ps
`default_nettype none

module rpm_from_capture_period_top
    import rfcp_pkg::*;
#(
    parameter int CAPTURE_BITS = DEF_CAPTURE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [NUM_W-1:0]      i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_in_operation,
    input  wire logic [CAP_PORT_W-1:0] i_in_capture_value,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [SPEED_W-1:0]         o_out_speed_rpm,
    output logic                       o_out_zero_interval
);

    t_state              r_state;
    t_state              n_state;
    logic [NUM_W-1:0]    r_numerator;
    logic [SPEED_W-1:0]  r_res_speed;
    logic [SPEED_W-1:0]  n_res_speed;
    logic                r_res_zero;
    logic                n_res_zero;
    logic                r_out_valid;
    logic [SPEED_W-1:0]  r_out_speed;
    logic                r_out_zero;
    logic                in_accept;
    logic                is_capture;
    logic                period_zero;
    logic                out_free;
    logic                div_start;
    logic                load_out;
    logic [NUM_W-1:0]    period;
    logic [NUM_W-1:0]    quotient;
    t_div_status         div_stat;

    assign in_accept   = i_in_valid & ~o_in_stall;
    assign is_capture  = (i_in_operation == OP_CAPTURE);
    assign period_zero = (period == '0);
    assign out_free    = ~r_out_valid | ~i_out_stall;

    rfcp_period #(
        .CAPTURE_BITS (CAPTURE_BITS)
    ) u_period (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_operation     (i_in_operation),
        .i_capture_value (i_in_capture_value),
        .o_period        (period)
    );

    rfcp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_numerator),
        .i_divisor  (period),
        .o_status   (div_stat),
        .o_quotient (quotient)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && is_capture) begin
                    n_state = period_zero ? ST_HOLD : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        div_start   = 1'b0;
        load_out    = 1'b0;
        n_res_speed = r_res_speed;
        n_res_zero  = r_res_zero;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (in_accept && is_capture) begin
                    div_start   = ~period_zero;
                    n_res_speed = SPEED_SAT;
                    n_res_zero  = period_zero;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_res_speed = quotient[SPEED_W-1:0];
                    n_res_zero  = 1'b0;
                end
            end
            ST_HOLD: begin
                load_out = out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_numerator <= NUM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_numerator <= i_cfg_wdata;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_speed <= n_res_speed;
        r_res_zero  <= n_res_zero;
        if (load_out) begin
            r_out_speed <= r_res_speed;
            r_out_zero  <= r_res_zero;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_speed_rpm     = r_out_speed;
    assign o_out_zero_interval = r_out_zero;

    a_out_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_HOLD))
        else $error("output valid rose outside hold");

    a_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_zero_interval) |-> (o_out_speed_rpm == SPEED_SAT))
        else $error("zero period without saturated speed");

    a_div_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("sequencer waits on an idle divider");

    a_capture_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && is_capture) |=> (r_state != ST_IDLE))
        else $error("capture accepted without leaving idle");

endmodule

`default_nettype wire
